@@ rtl/utp_pkg.sv @@
// Shared types and constants for the UTF-8 typographic to ASCII converter.
package utp_pkg;

  // Decoder phase: how much of a multi-byte sequence has been seen.
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_E2    = 3'd1,
    PH_E2_80 = 3'd2,
    PH_E2_88 = 3'd3,
    PH_C2    = 3'd4,
    PH_SKIP  = 3'd5
  } phase_t;

  // One decoded token: a single character, or the three-dot expansion.
  typedef struct packed {
    logic [6:0] ch;
    logic       triple;
  } tok_t;

  localparam logic [7:0] BYTE_E2     = 8'hE2;
  localparam logic [7:0] BYTE_C2     = 8'hC2;
  localparam logic [7:0] BYTE_80     = 8'h80;
  localparam logic [7:0] BYTE_88     = 8'h88;
  localparam logic [7:0] BYTE_92     = 8'h92;
  localparam logic [7:0] BYTE_93     = 8'h93;
  localparam logic [7:0] BYTE_94     = 8'h94;
  localparam logic [7:0] BYTE_98     = 8'h98;
  localparam logic [7:0] BYTE_99     = 8'h99;
  localparam logic [7:0] BYTE_9C     = 8'h9C;
  localparam logic [7:0] BYTE_9D     = 8'h9D;
  localparam logic [7:0] BYTE_A0     = 8'hA0;
  localparam logic [7:0] BYTE_A6     = 8'hA6;

  localparam logic [6:0] CHAR_APOS   = 7'h27;
  localparam logic [6:0] CHAR_QUOTE  = 7'h22;
  localparam logic [6:0] CHAR_DASH   = 7'h2D;
  localparam logic [6:0] CHAR_DOT    = 7'h2E;
  localparam logic [6:0] CHAR_SPACE  = 7'h20;

endpackage

@@ rtl/utp_if.sv @@
// Valid/ready channel interfaces for the byte input and the character output.
interface utp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface utp_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       run_end;

  modport source (output valid, output out_char, output run_end, input ready);
  modport sink   (input valid, input out_char, input run_end, output ready);
endinterface

@@ rtl/utp_front.sv @@
// Front end: tracks the UTF-8 decode phase and turns each byte into a token or nothing.
module utp_front (
  input  logic           clk,
  input  logic           rst,
  utp_byte_if.sink       utf8,
  output logic           tok_valid,
  input  logic           tok_ready,
  output utp_pkg::tok_t  tok
);

  utp_pkg::phase_t phase;
  utp_pkg::phase_t phase_next;
  utp_pkg::phase_t start_phase;
  logic            start_emit;
  logic            is_cont;
  logic            emit;
  logic [7:0]      b;
  logic            accept;

  assign b         = utf8.in_byte;
  assign is_cont   = (b[7:6] == 2'b10);
  assign utf8.ready = tok_ready;
  assign accept    = utf8.valid && tok_ready;
  assign tok_valid = utf8.valid && emit;

  // Handling of a byte with no sequence pending.
  always_comb begin
    start_emit  = 1'b0;
    start_phase = utp_pkg::PH_SKIP;
    if (!b[7]) begin
      start_emit  = 1'b1;
      start_phase = utp_pkg::PH_IDLE;
    end else if (b == utp_pkg::BYTE_E2) begin
      start_phase = utp_pkg::PH_E2;
    end else if (b == utp_pkg::BYTE_C2) begin
      start_phase = utp_pkg::PH_C2;
    end
  end

  always_comb begin
    emit       = 1'b0;
    tok.ch     = b[6:0];
    tok.triple = 1'b0;
    phase_next = phase;
    case (phase)
      utp_pkg::PH_E2: begin
        if (b == utp_pkg::BYTE_80) begin
          phase_next = utp_pkg::PH_E2_80;
        end else if (b == utp_pkg::BYTE_88) begin
          phase_next = utp_pkg::PH_E2_88;
        end else if (is_cont) begin
          phase_next = utp_pkg::PH_SKIP;
        end else begin
          emit       = start_emit;
          phase_next = start_phase;
        end
      end
      utp_pkg::PH_E2_80: begin
        phase_next = utp_pkg::PH_IDLE;
        if (b == utp_pkg::BYTE_98 || b == utp_pkg::BYTE_99) begin
          emit   = 1'b1;
          tok.ch = utp_pkg::CHAR_APOS;
        end else if (b == utp_pkg::BYTE_9C || b == utp_pkg::BYTE_9D) begin
          emit   = 1'b1;
          tok.ch = utp_pkg::CHAR_QUOTE;
        end else if (b == utp_pkg::BYTE_93 || b == utp_pkg::BYTE_94) begin
          emit   = 1'b1;
          tok.ch = utp_pkg::CHAR_DASH;
        end else if (b == utp_pkg::BYTE_A6) begin
          emit       = 1'b1;
          tok.ch     = utp_pkg::CHAR_DOT;
          tok.triple = 1'b1;
        end else if (is_cont) begin
          phase_next = utp_pkg::PH_SKIP;
        end else begin
          emit       = start_emit;
          phase_next = start_phase;
        end
      end
      utp_pkg::PH_E2_88: begin
        if (b == utp_pkg::BYTE_92) begin
          emit       = 1'b1;
          tok.ch     = utp_pkg::CHAR_DASH;
          phase_next = utp_pkg::PH_IDLE;
        end else if (is_cont) begin
          phase_next = utp_pkg::PH_SKIP;
        end else begin
          emit       = start_emit;
          phase_next = start_phase;
        end
      end
      utp_pkg::PH_C2: begin
        if (b == utp_pkg::BYTE_A0) begin
          emit       = 1'b1;
          tok.ch     = utp_pkg::CHAR_SPACE;
          phase_next = utp_pkg::PH_IDLE;
        end else if (is_cont) begin
          phase_next = utp_pkg::PH_SKIP;
        end else begin
          emit       = start_emit;
          phase_next = start_phase;
        end
      end
      utp_pkg::PH_SKIP: begin
        if (!is_cont) begin
          emit       = start_emit;
          phase_next = start_phase;
        end
      end
      default: begin
        emit       = start_emit;
        phase_next = start_phase;
      end
    endcase
    // The end of a string abandons any partial sequence.
    if (utf8.in_last) begin
      phase_next = utp_pkg::PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= utp_pkg::PH_IDLE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

endmodule

@@ rtl/utp_queue.sv @@
// Small token FIFO that decouples the decoder from the character expander.
module utp_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  utp_pkg::tok_t push_tok,
  output logic          pop_valid,
  input  logic          pop_ready,
  output utp_pkg::tok_t pop_tok
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  utp_pkg::tok_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_tok    = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/utp_back.sv @@
// Back end: expands tokens into characters and holds them in the output register.
module utp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          tok_valid,
  output logic          tok_ready,
  input  utp_pkg::tok_t tok,
  utp_char_if.source    ascii
);

  logic       out_valid;
  logic [6:0] out_char;
  logic       run_end;
  logic [1:0] dots_left;
  logic       load;

  assign load        = !out_valid || ascii.ready;
  assign tok_ready   = load && (dots_left == 2'd0);
  assign ascii.valid    = out_valid;
  assign ascii.out_char = out_char;
  assign ascii.run_end  = run_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      dots_left <= 2'd0;
    end else if (load) begin
      if (dots_left != 2'd0) begin
        out_valid <= 1'b1;
        dots_left <= dots_left - 2'd1;
      end else if (tok_valid) begin
        out_valid <= 1'b1;
        dots_left <= tok.triple ? 2'd2 : 2'd0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (dots_left != 2'd0) begin
        out_char <= utp_pkg::CHAR_DOT;
        run_end  <= (dots_left == 2'd1);
      end else if (tok_valid) begin
        out_char <= tok.ch;
        run_end  <= !tok.triple;
      end
    end
  end

endmodule

@@ rtl/utf8_typographic_to_ascii.sv @@
// Top level of the UTF-8 typographic to ASCII converter.
//
// The utf8 channel takes one byte of UTF-8 text per transfer, with in_last set
// on the final byte of a string. The ascii channel returns plain characters,
// with run_end set on the last character that one input byte produced.
// ASCII bytes pass straight through; curly quotes, dashes, the minus sign, the
// non-breaking space and the ellipsis become their plain forms; any other
// non-ASCII sequence is dropped, and a partial sequence at the end of a string
// produces nothing.
// The front decoder accepts one byte per cycle whenever the token queue has
// room, so throughput is one byte per cycle. An accepted byte passes through
// the token queue, then the output register, before its first character reaches
// the ascii channel. An ellipsis produces three characters, and the token queue
// absorbs the extra ones. Because an ellipsis arrives as three input bytes, even
// a long run of them keeps the input at one byte per cycle while the receiver is
// ready. When the receiver stalls, the output register holds its character, the
// queue fills, and utf8.ready drops once it is full. Reset empties the queue and
// the output register and returns the decoder to its idle phase.
module utf8_typographic_to_ascii #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  utp_byte_if.sink   utf8,
  utp_char_if.source ascii
);

  // Tokens from the decoder into the queue.
  logic          f_valid;
  logic          f_ready;
  utp_pkg::tok_t f_tok;

  // Tokens from the queue into the expander.
  logic          b_valid;
  logic          b_ready;
  utp_pkg::tok_t b_tok;

  utp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .utf8      (utf8),
    .tok_valid (f_valid),
    .tok_ready (f_ready),
    .tok       (f_tok)
  );

  utp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_tok   (f_tok),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_tok    (b_tok)
  );

  utp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (b_valid),
    .tok_ready (b_ready),
    .tok       (b_tok),
    .ascii     (ascii)
  );

endmodule

@@ test/tb_utf8_typographic_to_ascii.sv @@
// Self-checking testbench for the UTF-8 typographic to ASCII converter.
`timescale 1ns / 1ps

module tb_utf8_typographic_to_ascii;

  // Input bytes to send in total, directed part included.
  localparam int unsigned ITEMS = 330;
  // During the final stretch of input neither side idles.
  localparam int unsigned QUIET_TAIL = 50;
  // The receiver's long hold-off starts once this many bytes have been sent.
  localparam int unsigned HOLD_AT = 120;
  localparam int unsigned HOLD_CYCLES = 60;
  // Covers the path through the queue and output register, with margin.
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned LIMIT_CYCLES = 200000;

  // Directed opening. Bit 8 is the end-of-string flag and bits 7:0 the byte.
  localparam logic [8:0] OPENING [28] = '{
    9'h000, 9'h17F,                  // zero byte, then the top ASCII code ends a string
    9'h0E2, 9'h080, 9'h098,          // left single quote
    9'h0E2, 9'h080, 9'h09D,          // right double quote
    9'h0E2, 9'h080, 9'h094,          // em dash
    9'h0E2, 9'h088, 9'h092,          // minus sign
    9'h0E2, 9'h080, 9'h0A6,          // ellipsis, three characters
    9'h0C2, 9'h0A0,                  // non-breaking space
    9'h0E2, 9'h041,                  // broken by ASCII, which is then passed
    9'h0FF, 9'h080, 9'h041,          // unknown lead byte and its continuation dropped
    9'h0E2, 9'h180,                  // partial sequence cut off by end of string
    9'h1A6,                          // stray continuation byte at the end of a string
    9'h021                           // decoder must be idle again here
  };

  // One expected character on the ascii channel.
  typedef struct packed {
    logic [6:0] ch;
    logic       run_end;
  } ascii_out_t;

  // Tracks the decoder phase the way the block should, and holds the
  // characters that accepted bytes are due to produce, oldest first.
  class translit_board;
    utp_pkg::phase_t phase;
    ascii_out_t      pending_chars [$];
    int unsigned     errors;

    function new();
      phase = utp_pkg::PH_IDLE;
      errors = 0;
    endfunction

    // Queues count copies of one character; run_end marks the last copy.
    function void emit(logic [6:0] c, int unsigned count);
      for (int unsigned k = 0; k < count; k++)
        pending_chars.push_back('{ch: c, run_end: (k == count - 1)});
    endfunction

    // A byte seen with no sequence pending.
    function void fresh_byte(logic [7:0] b);
      if (!b[7]) begin
        emit(b[6:0], 1);
        phase = utp_pkg::PH_IDLE;
      end else if (b == utp_pkg::BYTE_E2) begin
        phase = utp_pkg::PH_E2;
      end else if (b == utp_pkg::BYTE_C2) begin
        phase = utp_pkg::PH_C2;
      end else begin
        phase = utp_pkg::PH_SKIP;
      end
    endfunction

    // The pending sequence is dropped; a continuation byte starts a skip run.
    function void break_seq(logic [7:0] b);
      if (b[7:6] == 2'b10)
        phase = utp_pkg::PH_SKIP;
      else
        fresh_byte(b);
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      case (phase)
        utp_pkg::PH_E2: begin
          if (b == utp_pkg::BYTE_80) phase = utp_pkg::PH_E2_80;
          else if (b == utp_pkg::BYTE_88) phase = utp_pkg::PH_E2_88;
          else break_seq(b);
        end
        utp_pkg::PH_E2_80: begin
          if (b == utp_pkg::BYTE_98 || b == utp_pkg::BYTE_99) begin
            phase = utp_pkg::PH_IDLE;
            emit(utp_pkg::CHAR_APOS, 1);
          end else if (b == utp_pkg::BYTE_9C || b == utp_pkg::BYTE_9D) begin
            phase = utp_pkg::PH_IDLE;
            emit(utp_pkg::CHAR_QUOTE, 1);
          end else if (b == utp_pkg::BYTE_93 || b == utp_pkg::BYTE_94) begin
            phase = utp_pkg::PH_IDLE;
            emit(utp_pkg::CHAR_DASH, 1);
          end else if (b == utp_pkg::BYTE_A6) begin
            phase = utp_pkg::PH_IDLE;
            emit(utp_pkg::CHAR_DOT, 3);
          end else begin
            break_seq(b);
          end
        end
        utp_pkg::PH_E2_88: begin
          if (b == utp_pkg::BYTE_92) begin
            phase = utp_pkg::PH_IDLE;
            emit(utp_pkg::CHAR_DASH, 1);
          end else begin
            break_seq(b);
          end
        end
        utp_pkg::PH_C2: begin
          if (b == utp_pkg::BYTE_A0) begin
            phase = utp_pkg::PH_IDLE;
            emit(utp_pkg::CHAR_SPACE, 1);
          end else begin
            break_seq(b);
          end
        end
        utp_pkg::PH_SKIP: begin
          if (b[7:6] != 2'b10) fresh_byte(b);
        end
        default: fresh_byte(b);
      endcase
      // End of string always leaves the decoder idle.
      if (last) phase = utp_pkg::PH_IDLE;
    endfunction

    function void check_char(logic [6:0] ch, logic run_end);
      ascii_out_t want;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected char 0x%h run_end %b, none expected", $time, ch, run_end);
        errors++;
        return;
      end
      want = pending_chars.pop_front();
      if (want.ch !== ch) begin
        $display("%0t: out_char expected 0x%h, got 0x%h", $time, want.ch, ch);
        errors++;
      end
      if (want.run_end !== run_end) begin
        $display("%0t: run_end expected %b, got %b", $time, want.run_end, run_end);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  utp_byte_if utf8 ();
  utp_char_if ascii ();

  utf8_typographic_to_ascii uut (
    .clk   (clk),
    .rst   (rst),
    .utf8  (utf8),
    .ascii (ascii)
  );

  translit_board board = new();

  // Set at each rising edge when the utf8 channel completed a transfer; the
  // sender reads it at the following falling edge.
  bit byte_taken;
  // Once set, neither side inserts idle cycles any more.
  bit quiet;
  // Raised by the sender to ask the receiver for its long hold-off; the
  // receiver lowers it when the hold-off is over.
  bit hold_req;
  bit hold_done;
  int unsigned items_sent;
  int unsigned cycles;

  initial begin
    forever #1 clk = ~clk;
  end

  // Both channels are sampled at the rising edge, while the inputs only move
  // at the falling edge, so the sampled values are settled. Bytes are noted
  // before characters are checked, although a character can never come from
  // a byte accepted at the same edge.
  always @(posedge clk) begin
    byte_taken = !rst && utf8.valid && utf8.ready;
    if (byte_taken)
      board.note_byte(utf8.in_byte, utf8.in_last);
    if (!rst && ascii.valid && ascii.ready)
      board.check_char(ascii.out_char, ascii.run_end);
  end

  // Watchdog: a run that is stuck ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_utf8_typographic_to_ascii NOT OK");
      $finish;
    end
  end

  // Receiver: ready comes in random runs high and low, a long hold-off on
  // request, and stays high once the run turns quiet. Each pass of the loop
  // assigns ready once and then lets at least one falling edge go by.
  initial begin
    forever begin
      if (hold_req) begin
        ascii.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (quiet) begin
        ascii.ready <= 1'b1;
        @(negedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        ascii.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end else begin
        ascii.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  // Offers one byte, starting at a falling edge, and returns at the falling
  // edge after its transfer. Sometimes a burst of idle cycles comes first,
  // but never during the hold-off, so that the queue fills up behind it.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!quiet && !hold_req && $urandom_range(0, 5) == 0) begin
      utf8.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    utf8.valid   <= 1'b1;
    utf8.in_byte <= b;
    utf8.in_last <= last;
    do @(negedge clk); while (!byte_taken);
    items_sent++;
    if (items_sent + QUIET_TAIL >= ITEMS) quiet = 1'b1;
  endtask

  // One random group of bytes. Most groups are well-formed typographic
  // sequences or plain text; the rest are unknown sequences, broken
  // prefixes and single random bytes. The end-of-string flag lands mostly on
  // the last byte of a group, now and then in the middle of one.
  task automatic send_random_group();
    logic [7:0] seq [$];
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      case ($urandom_range(0, 8))
        0: seq = '{utp_pkg::BYTE_E2, utp_pkg::BYTE_80, utp_pkg::BYTE_98};
        1: seq = '{utp_pkg::BYTE_E2, utp_pkg::BYTE_80, utp_pkg::BYTE_99};
        2: seq = '{utp_pkg::BYTE_E2, utp_pkg::BYTE_80, utp_pkg::BYTE_9C};
        3: seq = '{utp_pkg::BYTE_E2, utp_pkg::BYTE_80, utp_pkg::BYTE_9D};
        4: seq = '{utp_pkg::BYTE_E2, utp_pkg::BYTE_80, utp_pkg::BYTE_93};
        5: seq = '{utp_pkg::BYTE_E2, utp_pkg::BYTE_80, utp_pkg::BYTE_94};
        6: seq = '{utp_pkg::BYTE_E2, utp_pkg::BYTE_88, utp_pkg::BYTE_92};
        7: seq = '{utp_pkg::BYTE_E2, utp_pkg::BYTE_80, utp_pkg::BYTE_A6};
        default: seq = '{utp_pkg::BYTE_C2, utp_pkg::BYTE_A0};
      endcase
    end else if (kind < 65) begin
      n = $urandom_range(1, 4);
      repeat (n) seq.push_back(8'($urandom_range(0, 127)));
    end else if (kind < 75) begin
      // Some other multi-byte character: lead byte plus continuation bytes.
      seq.push_back(8'($urandom_range(8'hC0, 8'hFF)));
      n = $urandom_range(0, 3);
      repeat (n) seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
    end else if (kind < 85) begin
      // A known prefix broken by an arbitrary byte.
      case ($urandom_range(0, 3))
        0: seq = '{utp_pkg::BYTE_E2};
        1: seq = '{utp_pkg::BYTE_E2, utp_pkg::BYTE_80};
        2: seq = '{utp_pkg::BYTE_E2, utp_pkg::BYTE_88};
        default: seq = '{utp_pkg::BYTE_C2};
      endcase
      seq.push_back(8'($urandom_range(0, 255)));
    end else begin
      seq.push_back(8'($urandom_range(0, 255)));
    end
    foreach (seq[i])
      send_byte(seq[i], (i == seq.size() - 1) ? ($urandom_range(0, 5) == 0)
                                              : ($urandom_range(0, 29) == 0));
  endtask

  // Stimulus: reset, the directed opening, then random groups with one long
  // hold-off on the receiver side, and finally a drain of the ascii channel.
  initial begin
    rst          <= 1'b1;
    utf8.valid   <= 1'b0;
    utf8.in_byte <= 8'h00;
    utf8.in_last <= 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (OPENING[i])
      send_byte(OPENING[i][7:0], OPENING[i][8]);

    while (items_sent < ITEMS) begin
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      send_random_group();
    end
    utf8.valid <= 1'b0;

    // The watchdog catches characters that never arrive.
    while (board.pending_chars.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (board.errors == 0 && board.pending_chars.size() == 0)
      $display("tb_utf8_typographic_to_ascii OK");
    else
      $display("tb_utf8_typographic_to_ascii NOT OK");
    $finish;
  end

endmodule

@@ utf8_typographic_to_ascii.f @@
rtl/utp_pkg.sv
rtl/utp_if.sv
rtl/utp_front.sv
rtl/utp_queue.sv
rtl/utp_back.sv
rtl/utf8_typographic_to_ascii.sv
test/tb_utf8_typographic_to_ascii.sv
